// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top level of the literal lexer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_AT(label, clk, rst_n, !(cond))
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/nll_pkg.sv -----
// shared types, codes and helpers of the numeric literal lexer
package nll_pkg;

  // longest literal length that the counters track
  localparam int LEN_MAX = 255;
  localparam int LEN_W   = $clog2(LEN_MAX + 1);
  localparam int NFLAGS  = 10;

  typedef logic [LEN_W-1:0] len_t;

  // request commands
  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // literal bases
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_t;

  // class of the previous consumed character
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_SEP  = 2'd1,
    CLS_DOT  = 2'd2,
    CLS_SIGN = 2'd3
  } cls_t;

  // status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_FLOAT_IN_INT = 4'd11;

  // flag bit positions, one below the status code
  localparam int F_EXP_DOT    = 0;
  localparam int F_MULTI_DOT  = 1;
  localparam int F_SEP_MARKER = 2;
  localparam int F_SEP_SEP    = 3;
  localparam int F_SEP_DOT    = 4;
  localparam int F_SEP_END    = 5;
  localparam int F_EXP_EMPTY  = 6;
  localparam int F_EXP_CHAR   = 7;
  localparam int F_UNDERSCORE = 8;
  localparam int F_MANT_CHAR  = 9;

  // characters of interest
  localparam logic [7:0] CH_SEP   = 8'h27;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // literal state carried from character to character
  typedef struct packed {
    logic              active;
    radix_t            radix;
    cls_t              prev_class;
    logic              sep_at_start;
    logic              sign_window;
    logic [1:0]        exp_pos;
    logic              exp_has_digit;
    logic [1:0]        dot_count;
    logic [NFLAGS-1:0] error_flags;
    len_t              len_total;
    len_t              len_mantissa;
    logic              sep_after_dot;
  } nll_state_t;

  // one result
  typedef struct packed {
    logic [3:0] status;
    logic [7:0] total_len;
    logic [7:0] mantissa_len;
    logic       float_flag;
  } nll_result_t;

  // step outputs toward the register stage
  typedef struct packed {
    nll_state_t  state;
    logic        emit;
    nll_result_t result;
  } nll_step_t;

  // saturating length increment
  function automatic len_t nll_bump(len_t v);
    return (v < LEN_W'(LEN_MAX)) ? v + len_t'(1) : v;
  endfunction

  // clip a length to the 8-bit result field
  function automatic logic [7:0] nll_clip(len_t v);
    return (int'(v) > 255) ? 8'hff : 8'(v);
  endfunction

endpackage

// ----- rtl/core/nll_step.sv -----
// next-state and result logic for one request of the literal lexer
module nll_step (
  input  nll_pkg::nll_state_t state,
  input  logic [1:0]          cmd,
  input  logic [7:0]          ch,
  input  logic [1:0]          base,
  output nll_pkg::nll_step_t  step
);

  logic                      is_sep, is_dot, is_sign, is_digit, is_letter;
  logic                      is_marker, belongs, base_digit;
  logic [nll_pkg::NFLAGS-1:0] fin_flags;
  logic [3:0]                prio_status;
  logic                      lit_float;
  logic                      emit_now;
  nll_pkg::nll_state_t       nxt;
  nll_pkg::nll_state_t       clr;

  // character classes
  assign is_sep    = ch == nll_pkg::CH_SEP;
  assign is_dot    = ch == nll_pkg::CH_DOT;
  assign is_sign   = (ch == nll_pkg::CH_PLUS) || (ch == nll_pkg::CH_MINUS);
  assign is_digit  = (ch >= "0") && (ch <= "9");
  assign is_letter = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));

  // digit of the current base
  always_comb begin
    case (state.radix)
      nll_pkg::RADIX_DEC: base_digit = is_digit;
      nll_pkg::RADIX_HEX: base_digit = is_digit || ((ch >= "a") && (ch <= "f")) ||
                                       ((ch >= "A") && (ch <= "F"));
      nll_pkg::RADIX_OCT: base_digit = (ch >= "0") && (ch <= "7");
      default:            base_digit = (ch == "0") || (ch == "1");
    endcase
  end

  // exponent marker and membership
  assign is_marker = (state.exp_pos == 2'd0) &&
                     (((state.radix == nll_pkg::RADIX_DEC) && ((ch == "e") || (ch == "E"))) ||
                      ((state.radix == nll_pkg::RADIX_HEX) && ((ch == "p") || (ch == "P"))));
  assign belongs = is_marker || (state.sign_window && (is_sep || is_sign)) || is_letter ||
                   is_digit || (ch == nll_pkg::CH_UNDER) || is_dot || is_sep;

  // flags folded in at close, then priority pick
  always_comb begin
    fin_flags = state.error_flags;
    if (state.prev_class == nll_pkg::CLS_SEP) fin_flags[nll_pkg::F_SEP_END] = 1'b1;
    if ((state.exp_pos != 2'd0) && !state.exp_has_digit && !fin_flags[nll_pkg::F_EXP_CHAR])
      fin_flags[nll_pkg::F_EXP_EMPTY] = 1'b1;
    prio_status = nll_pkg::ST_OK;
    for (int k = nll_pkg::NFLAGS - 1; k >= 0; k--) begin
      if (fin_flags[k]) prio_status = 4'(k + 1);
    end
  end

  assign lit_float = (state.exp_pos != 2'd0) || (state.dot_count != 2'd0);

  // cleared literal for a begin request
  always_comb begin
    clr               = '0;
    clr.active        = 1'b1;
    clr.radix         = nll_pkg::radix_t'(base);
    clr.prev_class    = nll_pkg::CLS_NONE;
  end

  // state update
  always_comb begin
    nxt      = state;
    emit_now = 1'b0;
    case (nll_pkg::cmd_t'(cmd))
      nll_pkg::CMD_BEGIN: begin
        nxt = clr;
      end
      nll_pkg::CMD_END: begin
        if (state.active) begin
          emit_now   = 1'b1;
          nxt.active = 1'b0;
        end
      end
      nll_pkg::CMD_CHAR: begin
        if (state.active && !belongs) begin
          emit_now   = 1'b1;
          nxt.active = 1'b0;
        end else if (state.active && is_marker) begin
          if (state.prev_class == nll_pkg::CLS_SEP)
            nxt.error_flags[nll_pkg::F_SEP_MARKER] = 1'b1;
          nxt.exp_pos     = 2'd1;
          nxt.sign_window = 1'b1;
          nxt.prev_class  = nll_pkg::CLS_NONE;
          nxt.len_total   = nll_pkg::nll_bump(state.len_total);
        end else if (state.active) begin
          if (state.exp_pos != 2'd0) begin
            // exponent part
            if (is_sep && ((state.exp_pos == 2'd1) ||
                           ((state.exp_pos == 2'd2) && (state.prev_class == nll_pkg::CLS_SIGN))))
              nxt.error_flags[nll_pkg::F_SEP_MARKER] = 1'b1;
            if (is_dot) nxt.error_flags[nll_pkg::F_EXP_DOT] = 1'b1;
            if (!((state.exp_pos == 2'd1) && is_sign) && !is_sep) begin
              if (is_digit) nxt.exp_has_digit = 1'b1;
              else          nxt.error_flags[nll_pkg::F_EXP_CHAR] = 1'b1;
            end
            nxt.sign_window = state.sign_window && is_sep;
            nxt.exp_pos     = (state.exp_pos < 2'd3) ? state.exp_pos + 2'd1 : 2'd3;
          end else begin
            // mantissa part
            if ((state.prev_class == nll_pkg::CLS_SEP) && state.sep_after_dot)
              nxt.error_flags[nll_pkg::F_SEP_DOT] = 1'b1;
            if (is_dot) begin
              if ((state.prev_class == nll_pkg::CLS_SEP) && !state.sep_at_start)
                nxt.error_flags[nll_pkg::F_SEP_DOT] = 1'b1;
              if (state.dot_count != 2'd0) nxt.error_flags[nll_pkg::F_MULTI_DOT] = 1'b1;
              if (state.dot_count < 2'd3) nxt.dot_count = state.dot_count + 2'd1;
            end
            if (is_sep) begin
              nxt.sep_at_start  = state.len_mantissa == '0;
              nxt.sep_after_dot = state.prev_class == nll_pkg::CLS_DOT;
            end
            if (!is_sep && !is_dot && !base_digit)
              nxt.error_flags[nll_pkg::F_MANT_CHAR] = 1'b1;
            nxt.len_mantissa = nll_pkg::nll_bump(state.len_mantissa);
          end
          // checks common to both parts
          if (is_sep && (state.prev_class == nll_pkg::CLS_SEP))
            nxt.error_flags[nll_pkg::F_SEP_SEP] = 1'b1;
          if (ch == nll_pkg::CH_UNDER) nxt.error_flags[nll_pkg::F_UNDERSCORE] = 1'b1;
          nxt.prev_class = is_sep  ? nll_pkg::CLS_SEP  :
                           is_dot  ? nll_pkg::CLS_DOT  :
                           is_sign ? nll_pkg::CLS_SIGN : nll_pkg::CLS_NONE;
          nxt.len_total  = nll_pkg::nll_bump(state.len_total);
        end
      end
      default: begin
        nxt = state;
      end
    endcase
  end

  // result fields
  always_comb begin
    step.state               = nxt;
    step.emit                = emit_now;
    step.result.status       = ((prio_status == nll_pkg::ST_OK) && lit_float && state.radix[1]) ?
                               nll_pkg::ST_FLOAT_IN_INT : prio_status;
    step.result.total_len    = nll_pkg::nll_clip(state.len_total);
    step.result.mantissa_len = nll_pkg::nll_clip(state.len_mantissa);
    step.result.float_flag   = lit_float;
  end

endmodule

// ----- rtl/core/number_literal_lexer.sv -----
// top level of the numeric literal lexer: request and result registers around the step logic
//
// Requests arrive on in_* (cmd, ch, base) with in_valid/in_stall; a request is
// taken at a clock edge where in_valid is high and in_stall is low. A begin
// request opens a literal in the given base, character requests extend it, and
// the first character that does not belong or an end request closes it and
// produces one result on out_* (status, total_len, mantissa_len, float_flag).
// The terminating character itself is dropped.
// A closing request is loaded into the request register when it is taken, and its
// result is loaded into the result register when that request advances.
// Throughput: one request per cycle unless out_stall holds a result; the literal state
// is updated by one pass of the step logic between the request and result registers.
// When the receiver holds out_stall with a result pending, the request stage
// holds its request and in_stall rises; the result stays put until taken.
// Reset (rst_n low, synchronous) empties both stages and leaves no literal
// open, so characters and end requests are ignored until a begin.
`include "assert_macros.svh"

module number_literal_lexer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_ch,
  input  logic [1:0] in_base,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_status,
  output logic [7:0] out_total_len,
  output logic [7:0] out_mantissa_len,
  output logic       out_float_flag
);

  logic                  in_valid_r;
  logic [1:0]            in_cmd_r;
  logic [7:0]            in_ch_r;
  logic [1:0]            in_base_r;
  nll_pkg::nll_state_t   state_r;
  logic                  out_valid_r;
  nll_pkg::nll_result_t  result_r;
  nll_pkg::nll_step_t    step;
  logic                  advance;
  logic                  in_take;

  // request stage moves on when the result slot is free or being emptied
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  nll_step u_step (
    .state (state_r),
    .cmd   (in_cmd_r),
    .ch    (in_ch_r),
    .base  (in_base_r),
    .step  (step)
  );

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r  <= in_cmd;
      in_ch_r   <= in_ch;
      in_base_r <= in_base;
    end
  end

  // literal state, reset to decimal with no previous class
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= step.state;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step.emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      result_r <= step.result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = result_r.status;
  assign out_total_len    = result_r.total_len;
  assign out_mantissa_len = result_r.mantissa_len;
  assign out_float_flag   = result_r.float_flag;

  // a closed literal leaves no literal open
  `ASSERT_AT(a_emit_closes, clk, rst_n, (advance && step.emit) |=> !state_r.active)
  // the whole literal is never shorter than its mantissa
  `ASSERT_NEVER(a_len_order, clk, rst_n, state_r.len_mantissa > state_r.len_total)
  // no exponent digit or sign window without an exponent
  `ASSERT_NEVER(a_exp_flags, clk, rst_n,
                (state_r.exp_pos == 2'd0) && (state_r.exp_has_digit || state_r.sign_window))
  // a repeated point needs an earlier point
  `ASSERT_NEVER(a_dot_flag, clk, rst_n,
                (state_r.dot_count == 2'd0) && state_r.error_flags[nll_pkg::F_MULTI_DOT])

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the numeric literal lexer: directed literals, then random streams
module tb_top;
  import nll_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_LEN    = 80;
  localparam logic [7:0] CH_ZERO = "0";

  // literal state tracker that predicts one verdict per closed literal
  class literal_checker;
    bit                active;
    radix_t            radix;
    cls_t              prev_cls;
    bit                sep_at_start;
    bit                sign_window;
    logic [1:0]        exp_pos;
    bit                exp_has_digit;
    logic [1:0]        dot_count;
    logic [NFLAGS-1:0] flags;
    len_t              len_total;
    len_t              len_mant;
    bit                sep_after_dot;
    nll_result_t       pending_verdicts[$];
    int                used;
    int                closed;
    int                checked;
    int                errors;

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit base_digit(logic [7:0] c);
      case (radix)
        RADIX_DEC: return is_digit(c);
        RADIX_HEX: return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        RADIX_OCT: return c >= "0" && c <= "7";
        default:   return c == "0" || c == "1";
      endcase
    endfunction

    function len_t bump(len_t v);
      return (v < LEN_MAX) ? v + 1'b1 : v;
    endfunction

    // close the open literal and queue its verdict
    function void close_literal();
      logic [NFLAGS-1:0] f;
      nll_result_t       r;
      bit                flt;
      f   = flags;
      flt = exp_pos != 0 || dot_count != 0;
      if (prev_cls == CLS_SEP) f[F_SEP_END] = 1'b1;
      if (exp_pos != 0 && !exp_has_digit && !f[F_EXP_CHAR]) f[F_EXP_EMPTY] = 1'b1;
      // lowest flag wins
      r.status = ST_OK;
      for (int k = NFLAGS - 1; k >= 0; k--) begin
        if (f[k]) r.status = 4'(k + 1);
      end
      if (r.status == ST_OK && flt && radix >= RADIX_OCT) r.status = ST_FLOAT_IN_INT;
      r.total_len    = 8'(len_total);
      r.mantissa_len = 8'(len_mant);
      r.float_flag   = flt;
      pending_verdicts.push_back(r);
      active = 1'b0;
      closed++;
    endfunction

    // update the literal state with one accepted request
    function void take_request(cmd_t cmd, logic [7:0] c, radix_t b);
      bit         sep;
      bit         dot;
      bit         sgn;
      bit         marker;
      bit         belongs;
      logic [1:0] idx;
      if (cmd == CMD_BEGIN) begin
        radix         = b;
        active        = 1'b1;
        prev_cls      = CLS_NONE;
        sep_at_start  = 1'b0;
        sign_window   = 1'b0;
        exp_pos       = 2'd0;
        exp_has_digit = 1'b0;
        dot_count     = 2'd0;
        flags         = '0;
        len_total     = '0;
        len_mant      = '0;
        sep_after_dot = 1'b0;
        used++;
        return;
      end
      if (cmd == CMD_NOP || !active) return;
      used++;
      if (cmd == CMD_END) begin
        close_literal();
        return;
      end

      sep    = c == CH_SEP;
      dot    = c == CH_DOT;
      sgn    = c == CH_PLUS || c == CH_MINUS;
      marker = exp_pos == 0 && ((radix == RADIX_DEC && (c == "e" || c == "E")) ||
                                (radix == RADIX_HEX && (c == "p" || c == "P")));
      belongs = marker || (sign_window && (sep || sgn)) || is_letter(c) || is_digit(c) ||
                c == CH_UNDER || dot || sep;
      if (!belongs) begin
        close_literal();
        return;
      end

      // exponent marker opens the exponent
      if (marker) begin
        if (prev_cls == CLS_SEP) flags[F_SEP_MARKER] = 1'b1;
        exp_pos     = 2'd1;
        sign_window = 1'b1;
        prev_cls    = CLS_NONE;
        len_total   = bump(len_total);
        return;
      end

      if (exp_pos != 0) begin
        // exponent character
        idx = exp_pos;
        if (sep && (idx == 1 || (idx == 2 && prev_cls == CLS_SIGN))) flags[F_SEP_MARKER] = 1'b1;
        if (dot) flags[F_EXP_DOT] = 1'b1;
        if (idx == 1 && sgn) begin
          // sign right after the marker
        end else if (sep) begin
          // separator does not count as digit
        end else if (is_digit(c)) begin
          exp_has_digit = 1'b1;
        end else begin
          flags[F_EXP_CHAR] = 1'b1;
        end
        sign_window = sign_window && sep;
        exp_pos     = (idx < 3) ? idx + 2'd1 : 2'd3;
      end else begin
        // mantissa character
        if (prev_cls == CLS_SEP && sep_after_dot) flags[F_SEP_DOT] = 1'b1;
        if (dot) begin
          if (prev_cls == CLS_SEP && !sep_at_start) flags[F_SEP_DOT] = 1'b1;
          if (dot_count != 0) flags[F_MULTI_DOT] = 1'b1;
          if (dot_count < 3) dot_count++;
        end
        if (sep) begin
          sep_at_start  = len_mant == 0;
          sep_after_dot = prev_cls == CLS_DOT;
        end
        if (!sep && !dot && !base_digit(c)) flags[F_MANT_CHAR] = 1'b1;
        len_mant = bump(len_mant);
      end

      if (sep && prev_cls == CLS_SEP) flags[F_SEP_SEP] = 1'b1;
      if (c == CH_UNDER) flags[F_UNDERSCORE] = 1'b1;
      prev_cls  = sep ? CLS_SEP : dot ? CLS_DOT : sgn ? CLS_SIGN : CLS_NONE;
      len_total = bump(len_total);
    endfunction

    // compare one accepted result with the oldest predicted verdict
    function void compare_verdict(logic [3:0] st, logic [7:0] tl, logic [7:0] ml, logic fl);
      nll_result_t want;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: status %0d total %0d mantissa %0d float %0b",
                 $time, st, tl, ml, fl);
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      if (st !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
      if (tl !== want.total_len) begin
        errors++;
        $display("%0t: total_len expected %0d actual %0d", $time, want.total_len, tl);
      end
      if (ml !== want.mantissa_len) begin
        errors++;
        $display("%0t: mantissa_len expected %0d actual %0d", $time, want.mantissa_len, ml);
      end
      if (fl !== want.float_flag) begin
        errors++;
        $display("%0t: float_flag expected %0b actual %0b", $time, want.float_flag, fl);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_cmd;
  logic [7:0] in_ch;
  logic [1:0] in_base;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_status;
  logic [7:0] out_total_len;
  logic [7:0] out_mantissa_len;
  logic       out_float_flag;

  int  gap_pct   = 0;
  int  stall_pct = 0;
  bit  hold_req  = 1'b0;
  int  hold_cnt  = 0;
  int  quiet     = 0;
  literal_checker verdicts = new();

  number_literal_lexer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_ch            (in_ch),
    .in_base          (in_base),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_total_len    (out_total_len),
    .out_mantissa_len (out_mantissa_len),
    .out_float_flag   (out_float_flag)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check taken results, then pick next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      verdicts.compare_verdict(out_status, out_total_len, out_mantissa_len, out_float_flag);
    end
    if (hold_req && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("number_literal_lexer: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic radix_t any_base();
    return radix_t'($urandom_range(3));
  endfunction

  function automatic logic [7:0] odd_char();
    string odd;
    odd = "'._+-eEpPgxZ_09 ;)";
    return odd[$urandom_range(odd.len() - 1)];
  endfunction

  function automatic logic [7:0] digit_of(radix_t b);
    string hexd;
    hexd = "0123456789abcdefABCDEF";
    case (b)
      RADIX_DEC: return CH_ZERO + 8'($urandom_range(9));
      RADIX_HEX: return hexd[$urandom_range(21)];
      RADIX_OCT: return CH_ZERO + 8'($urandom_range(7));
      default:   return CH_ZERO + 8'($urandom_range(1));
    endcase
  endfunction

  // offer one request and wait until it is taken
  task automatic offer_request(cmd_t c, logic [7:0] ch, radix_t b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_ch    <= ch;
    in_base  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdicts.take_request(c, ch, b);
  endtask

  // begin a literal, feed the text, optionally close with an end request
  task automatic lex_text(radix_t b, string s, bit with_end);
    offer_request(CMD_BEGIN, 8'($urandom), b);
    foreach (s[i]) offer_request(CMD_CHAR, s[i], any_base());
    if (with_end) offer_request(CMD_END, 8'($urandom), any_base());
  endtask

  // mostly well-formed literal with random content and random termination
  task automatic random_literal();
    radix_t b;
    int     n;
    int     r;
    b = any_base();
    offer_request(CMD_BEGIN, 8'($urandom), b);
    n = ($urandom_range(299) == 0) ? $urandom_range(256, 270) : $urandom_range(8);
    repeat (n) begin
      r = $urandom_range(99);
      offer_request(CMD_CHAR, r < 75 ? digit_of(b) : r < 84 ? CH_SEP : r < 91 ? CH_DOT :
                    odd_char(), any_base());
    end
    // exponent part
    if ($urandom_range(99) < 45) begin
      if (b == RADIX_HEX) offer_request(CMD_CHAR, $urandom_range(1) ? "p" : "P", any_base());
      else offer_request(CMD_CHAR, $urandom_range(1) ? "e" : "E", any_base());
      while ($urandom_range(99) < 12) offer_request(CMD_CHAR, CH_SEP, any_base());
      if ($urandom_range(1)) begin
        offer_request(CMD_CHAR, $urandom_range(1) ? CH_PLUS : CH_MINUS, any_base());
      end
      repeat ($urandom_range(4)) begin
        r = $urandom_range(99);
        offer_request(CMD_CHAR, r < 80 ? CH_ZERO + 8'($urandom_range(9)) : r < 90 ? CH_SEP :
                      odd_char(), any_base());
      end
    end
    // end request, stray character, or left open for the next begin
    r = $urandom_range(99);
    if (r < 55) offer_request(CMD_END, 8'($urandom), any_base());
    else if (r < 90) offer_request(CMD_CHAR, 8'($urandom), any_base());
  endtask

  task automatic run_phase(int gap, int stall, int count);
    int target;
    gap_pct   = gap;
    stall_pct = stall;
    target    = verdicts.used + count;
    while (verdicts.used < target) begin
      if ($urandom_range(99) < 8) offer_request(cmd_t'($urandom_range(3)), 8'($urandom), any_base());
      else random_literal();
    end
  endtask

  // stimulus
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_cmd    = CMD_NOP;
    in_ch     = 8'h00;
    in_base   = RADIX_DEC;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // requests with no literal open are dropped
    offer_request(CMD_CHAR, "5", RADIX_DEC);
    offer_request(CMD_END, 8'hff, RADIX_BIN);
    lex_text(RADIX_DEC, "", 1'b1);
    lex_text(RADIX_DEC, "1.5e+3", 1'b1);
    lex_text(RADIX_HEX, "1f.8p-2", 1'b1);
    lex_text(RADIX_OCT, "17.2", 1'b1);
    lex_text(RADIX_BIN, "101", 1'b1);
    lex_text(RADIX_BIN, "1e1", 1'b1);
    lex_text(RADIX_DEC, "1e1.2", 1'b1);
    lex_text(RADIX_DEC, "1..2", 1'b1);
    lex_text(RADIX_DEC, "1'e5", 1'b1);
    lex_text(RADIX_DEC, "1e'5", 1'b1);
    lex_text(RADIX_DEC, "1e+'5", 1'b1);
    lex_text(RADIX_DEC, "1''2", 1'b1);
    lex_text(RADIX_DEC, "1.'2", 1'b1);
    lex_text(RADIX_DEC, "1'.2", 1'b1);
    lex_text(RADIX_DEC, "'.5", 1'b1);
    lex_text(RADIX_DEC, "12'", 1'b1);
    lex_text(RADIX_DEC, "1e", 1'b1);
    lex_text(RADIX_HEX, "ap-", 1'b1);
    lex_text(RADIX_DEC, "1e5x", 1'b1);
    lex_text(RADIX_DEC, "1_0", 1'b1);
    lex_text(RADIX_DEC, "12a", 1'b1);
    // terminating characters are dropped, trailing end is ignored
    lex_text(RADIX_DEC, "42 ", 1'b1);
    lex_text(RADIX_HEX, "aF", 1'b0);
    offer_request(CMD_CHAR, 8'hff, RADIX_HEX);
    lex_text(RADIX_BIN, "1", 1'b0);
    offer_request(CMD_CHAR, 8'h00, RADIX_BIN);
    // nop inside a literal, then a begin that drops the open literal
    lex_text(RADIX_DEC, "9", 1'b0);
    offer_request(CMD_NOP, "1", RADIX_HEX);
    lex_text(RADIX_DEC, "12", 1'b0);
    lex_text(RADIX_HEX, "b", 1'b1);
    // both lengths saturate
    offer_request(CMD_BEGIN, 8'h00, RADIX_DEC);
    repeat (260) offer_request(CMD_CHAR, "3", RADIX_DEC);
    offer_request(CMD_CHAR, "e", RADIX_DEC);
    repeat (10) offer_request(CMD_CHAR, "1", RADIX_DEC);
    offer_request(CMD_END, 8'h00, RADIX_DEC);

    // long result-side hold while requests keep coming
    hold_req <= 1'b1;
    repeat (30) lex_text(RADIX_DEC, "7", 1'b1);

    run_phase(0, 0, 225);
    run_phase(52, 0, 225);
    run_phase(0, 52, 225);
    run_phase(21, 21, 225);
    in_valid <= 1'b0;

    while (verdicts.pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("requests on open literals: %0d, literals closed: %0d, results checked: %0d",
             verdicts.used, verdicts.closed, verdicts.checked);
    $display("mixed bases, exponents, separators and stray bytes under four idle patterns");
    if (verdicts.errors == 0 && verdicts.pending_verdicts.size() == 0) begin
      $display("number_literal_lexer: match");
    end else begin
      $display("number_literal_lexer: mismatch");
    end
    $finish;
  end

endmodule
